>>> sv/mcavg_pkg.sv
package mcavg_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int WINDOW_DEF    = 16;

  localparam int ANGLE_W       = 12;
  localparam int CENTIDEG_W    = 16;
  localparam int CENTIDEG_FULL = 36000;
  localparam int PROD_W        = ANGLE_W + CENTIDEG_W;

endpackage

>>> sv/mcavg_div.sv
module mcavg_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [DEN_W:0]    trial;
  logic              fits;
  logic [DEN_W-1:0]  rem_nxt;
  logic [NUM_W-1:0]  quo_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
    quo_nxt = {quo_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> sv/multichannel_angle_moving_average.sv
// Per-channel moving average of 12-bit encoder angles. Each accepted word carries a
// channel, two raw bytes and a read-ok flag; a good reading is written into that
// channel's ring of WINDOW entries and the block returns the truncated mean of the
// entries written so far (all WINDOW once the ring has wrapped), plus that mean in
// hundredths of a degree. A failed read, or a channel at or above CHANNELS, leaves
// the history alone and returns zeros with valid_res low. One word at a time: a good
// reading is summed by a read pass over its channel's history memory (one entry a
// cycle, up to WINDOW entries), divided by the bit-serial divider (one quotient bit
// a cycle) and scaled to hundredths of a degree; a failed read goes straight to the
// output step. in_ready is low while a word is in work; a finished result waits in
// the output register while the next word is taken. The history memory needs no
// clearing after reset.
module multichannel_angle_moving_average #(
  parameter int CHANNELS = mcavg_pkg::CHANNELS_DEF,
  parameter int WINDOW   = mcavg_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_channel,
  input  logic [7:0]  in_raw_high,
  input  logic [7:0]  in_raw_low,
  input  logic        in_read_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_channel,
  output logic [11:0] out_average_raw,
  output logic [15:0] out_angle_centideg,
  output logic        out_valid_res
);

  localparam int ANGLE_W = mcavg_pkg::ANGLE_W;
  localparam int CDEG_W  = mcavg_pkg::CENTIDEG_W;
  localparam int PROD_W  = mcavg_pkg::PROD_W;
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WIN_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int DEPTH   = CHANNELS * WINDOW;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W   = ANGLE_W + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_MUL,
    S_FIN
  } state_t;

  state_t             state_r;
  logic [WIN_W-1:0]   wi_r [CHANNELS];
  logic               full_r [CHANNELS];
  logic [CH_W-1:0]    ch_r;
  logic [1:0]         out_ch_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   j_r;
  logic               rd_pend_r;
  logic [SUM_W-1:0]   acc_r;
  logic [ANGLE_W-1:0] avg_r;
  logic [CDEG_W-1:0]  ang_r;
  logic               ok_r;
  logic               div_start_r;

  logic               out_valid_r;
  logic [1:0]         out_ch_q_r;
  logic [ANGLE_W-1:0] out_avg_r;
  logic [CDEG_W-1:0]  out_ang_r;
  logic               out_ok_r;

  logic [ANGLE_W-1:0] mem [DEPTH];
  logic [ANGLE_W-1:0] rd_data_r;

  logic               accept;
  logic               good;
  logic [CH_W-1:0]    ch_in;
  logic [ANGLE_W-1:0] raw;
  logic [WIN_W-1:0]   idx_cur;
  logic [CNT_W-1:0]   idx_inc;
  logic               wrap;
  logic [WIN_W-1:0]   wi_nxt;
  logic               full_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we;
  logic [PROD_W-1:0]  prod;
  logic               div_done;
  logic [SUM_W-1:0]   div_quo;
  logic               out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ch_in    = CH_W'(in_channel);
  assign good     = in_read_ok && (int'(in_channel) < CHANNELS);
  assign raw      = {in_raw_high[3:0], in_raw_low};
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    idx_cur  = wi_r[ch_in];
    idx_inc  = CNT_W'(idx_cur) + CNT_W'(1);
    wrap     = (idx_inc == CNT_W'(WINDOW));
    wi_nxt   = wrap ? '0 : WIN_W'(idx_inc);
    full_nxt = full_r[ch_in] || wrap;
    cnt_nxt  = full_nxt ? CNT_W'(WINDOW) : idx_inc;
  end

  assign mem_we  = accept && good;
  assign wr_addr = ADDR_W'(ch_in) * ADDR_W'(WINDOW) + ADDR_W'(idx_cur);
  assign rd_addr = ADDR_W'(ch_r) * ADDR_W'(WINDOW) + ADDR_W'(j_r);
  assign prod    = PROD_W'(avg_r) * PROD_W'(mcavg_pkg::CENTIDEG_FULL);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= raw;
    end
    rd_data_r <= mem[rd_addr];
  end

  mcavg_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (acc_r),
    .den   (cnt_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wi_r[i]   <= '0;
        full_r[i] <= 1'b0;
      end
    end else begin
      div_start_r <= 1'b0;
      // the final step reloads the output register itself
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_ch_r <= in_channel;
            ch_r     <= ch_in;
            j_r      <= '0;
            acc_r    <= '0;
            if (good) begin
              wi_r[ch_in]   <= wi_nxt;
              full_r[ch_in] <= full_nxt;
              cnt_r         <= cnt_nxt;
              ok_r          <= 1'b1;
              state_r       <= S_SUM;
            end else begin
              avg_r   <= '0;
              ang_r   <= '0;
              ok_r    <= 1'b0;
              state_r <= S_FIN;
            end
          end
        end
        S_SUM: begin
          // read one entry a cycle; the registered data is added in the next cycle
          if (j_r != cnt_r) begin
            j_r       <= j_r + CNT_W'(1);
            rd_pend_r <= 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
          end
          if (rd_pend_r) begin
            acc_r <= acc_r + SUM_W'(rd_data_r);
          end
          if (j_r == cnt_r && !rd_pend_r) begin
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            avg_r   <= div_quo[ANGLE_W-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          ang_r   <= prod[PROD_W-1:ANGLE_W];
          state_r <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ch_q_r  <= out_ch_r;
            out_avg_r   <= avg_r;
            out_ang_r   <= ang_r;
            out_ok_r    <= ok_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_ch_q_r;
  assign out_average_raw    = out_avg_r;
  assign out_angle_centideg = out_ang_r;
  assign out_valid_res      = out_ok_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken while a word is in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> (out_average_raw == '0) && (out_angle_centideg == '0))
    else $error("rejected reading carries nonzero values");

  a_angle_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |->
      out_angle_centideg ==
        CDEG_W'((PROD_W'(out_average_raw) * PROD_W'(mcavg_pkg::CENTIDEG_FULL)) >> ANGLE_W))
    else $error("angle does not follow average");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide step");

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> cnt_r != '0)
    else $error("divide started with zero count");

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS      = mcavg_pkg::CHANNELS_DEF;
  localparam int WINDOW        = mcavg_pkg::WINDOW_DEF;
  localparam int ANGLE_W       = mcavg_pkg::ANGLE_W;
  localparam int CENTIDEG_W    = mcavg_pkg::CENTIDEG_W;
  localparam int CENTIDEG_FULL = mcavg_pkg::CENTIDEG_FULL;
  localparam int RANDOM_WORDS  = 230;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [1:0] ch;
    logic [7:0] hi;
    logic [7:0] lo;
    logic       ok;
  } reading_t;

  typedef struct packed {
    logic [1:0]            ch;
    logic [ANGLE_W-1:0]    avg;
    logic [CENTIDEG_W-1:0] cdeg;
    logic                  vld;
  } avg_result_t;

  typedef struct packed {
    reading_t    rd;
    logic        typed;
    avg_result_t res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_channel;
  logic [7:0]            in_raw_high;
  logic [7:0]            in_raw_low;
  logic                  in_read_ok;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_channel;
  logic [ANGLE_W-1:0]    out_average_raw;
  logic [CENTIDEG_W-1:0] out_angle_centideg;
  logic                  out_valid_res;

  multichannel_angle_moving_average #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_channel        (in_channel),
    .in_raw_high       (in_raw_high),
    .in_raw_low        (in_raw_low),
    .in_read_ok        (in_read_ok),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel       (out_channel),
    .out_average_raw   (out_average_raw),
    .out_angle_centideg(out_angle_centideg),
    .out_valid_res     (out_valid_res)
  );

  // predictor state
  logic [ANGLE_W-1:0] ring [CHANNELS][WINDOW];
  int unsigned        wr_ptr [CHANNELS];
  logic               wrapped [CHANNELS];

  avg_result_t avg_expect_q[$];
  stim_row_t   stim_table[$];

  int src_idle;
  int sink_idle;
  int mismatches;
  int words_sent;
  int results_checked;
  int failed_reads;
  int ring_wraps;
  int stall_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic avg_result_t predict_average(reading_t r);
    avg_result_t res;
    logic [ANGLE_W-1:0] angle;
    int unsigned count;
    int unsigned sum;
    int unsigned j;
    res = '{ch: r.ch, avg: '0, cdeg: '0, vld: 1'b0};
    if (!r.ok || r.ch >= CHANNELS) begin
      failed_reads++;
      return res;
    end
    angle = {r.hi[3:0], r.lo};
    ring[r.ch][wr_ptr[r.ch]] = angle;
    if (wr_ptr[r.ch] == WINDOW - 1) begin
      wr_ptr[r.ch] = 0;
      if (!wrapped[r.ch]) ring_wraps++;
      wrapped[r.ch] = 1'b1;
    end else begin
      wr_ptr[r.ch]++;
    end
    count = wrapped[r.ch] ? WINDOW : wr_ptr[r.ch];
    sum = 0;
    for (j = 0; j < count; j++) sum += ring[r.ch][j];
    res.avg  = ANGLE_W'(sum / count);
    res.cdeg = CENTIDEG_W'((int'(res.avg) * CENTIDEG_FULL) >> ANGLE_W);
    res.vld  = 1'b1;
    return res;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input reading_t r, input logic typed, input avg_result_t typed_res);
    avg_result_t pred;
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_channel  <= r.ch;
    in_raw_high <= r.hi;
    in_raw_low  <= r.lo;
    in_read_ok  <= r.ok;
    do @(posedge clk); while (!in_ready);
    pred = predict_average(r);
    avg_expect_q.push_back(typed ? typed_res : pred);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic add_row(input reading_t r, input logic typed, input avg_result_t res);
    stim_table.push_back('{rd: r, typed: typed, res: res});
  endtask

  // receiver pacing
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (avg_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t unexpected result word: ch=%0d avg=%0d cdeg=%0d vld=%0b", $realtime,
                   out_channel, out_average_raw, out_angle_centideg, out_valid_res);
      end else begin
        automatic avg_result_t exp_res = avg_expect_q.pop_front();
        results_checked++;
        if (out_channel !== exp_res.ch || out_average_raw !== exp_res.avg ||
            out_angle_centideg !== exp_res.cdeg || out_valid_res !== exp_res.vld) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch: exp ch=%0d avg=%0d cdeg=%0d vld=%0b,", $realtime,
                     exp_res.ch, exp_res.avg, exp_res.cdeg, exp_res.vld,
                     " got ch=%0d avg=%0d cdeg=%0d vld=%0b",
                     out_channel, out_average_raw, out_angle_centideg, out_valid_res);
        end
      end
    end
  end

  // hang detection: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    stall_cycles = 0;
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout after %0d idle cycles, %0d results outstanding", stall_cycles,
             avg_expect_q.size());
    $display("FAIL multichannel_angle_moving_average");
    $finish;
  end

  initial begin
    int phase;
    int k;
    int n;
    stim_row_t row;
    reading_t r;
    avg_result_t none;

    in_valid    = 1'b0;
    in_channel  = '0;
    in_raw_high = '0;
    in_raw_low  = '0;
    in_read_ok  = 1'b0;
    rst_n       = 1'b0;
    src_idle    = 8;
    sink_idle   = 62;
    mismatches      = 0;
    words_sent      = 0;
    results_checked = 0;
    failed_reads    = 0;
    ring_wraps      = 0;
    none = '0;
    for (k = 0; k < CHANNELS; k++) begin
      wr_ptr[k]  = 0;
      wrapped[k] = 1'b0;
    end

    // first reading of a channel averages to itself; upper nibble of raw_high ignored
    add_row('{ch: 2'd0, hi: 8'hFF, lo: 8'hFF, ok: 1'b1}, 1'b1,
            '{ch: 2'd0, avg: 12'd4095, cdeg: 16'd35991, vld: 1'b1});
    add_row('{ch: 2'd1, hi: 8'hF0, lo: 8'h00, ok: 1'b1}, 1'b1,
            '{ch: 2'd1, avg: 12'd0, cdeg: 16'd0, vld: 1'b1});
    add_row('{ch: 2'd2, hi: 8'h00, lo: 8'h00, ok: 1'b0}, 1'b1,
            '{ch: 2'd2, avg: 12'd0, cdeg: 16'd0, vld: 1'b0});
    add_row('{ch: 2'd3, hi: 8'hFF, lo: 8'hFF, ok: 1'b0}, 1'b1,
            '{ch: 2'd3, avg: 12'd0, cdeg: 16'd0, vld: 1'b0});
    add_row('{ch: 2'd3, hi: 8'h08, lo: 8'h00, ok: 1'b1}, 1'b1,
            '{ch: 2'd3, avg: 12'd2048, cdeg: 16'd18000, vld: 1'b1});
    add_row('{ch: 2'd2, hi: 8'h5A, lo: 8'h55, ok: 1'b1}, 1'b0, none);
    // fill channel 0 past one full ring, with a failed read in the middle
    for (k = 0; k < 18; k++) begin
      add_row('{ch: 2'd0, hi: 8'(k * 17), lo: 8'(255 - k * 13), ok: 1'b1}, 1'b0, none);
      if (k == 9)
        add_row('{ch: 2'd0, hi: 8'hAA, lo: 8'h33, ok: 1'b0}, 1'b1,
                '{ch: 2'd0, avg: 12'd0, cdeg: 16'd0, vld: 1'b0});
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      send_word(row.rd, row.typed, row.res);
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle = 8;  sink_idle = 62; end
        1: begin src_idle = 62; sink_idle = 8;  end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      n = 0;
      while (n < RANDOM_WORDS) begin
        // mostly good reads; sometimes a burst on one channel to drive wraps
        r.ch = 2'($urandom_range(0, CHANNELS - 1));
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : 1;
        repeat (k) begin
          r.ok = ($urandom_range(0, 99) >= 15);
          case ($urandom_range(0, 7))
            0: {r.hi, r.lo} = 16'hFFFF;
            1: {r.hi, r.lo} = 16'h0000;
            2: begin r.hi = 8'($urandom); r.lo = 8'hFF; end
            3: begin r.hi = 8'($urandom); r.lo = 8'h00; end
            default: {r.hi, r.lo} = 16'($urandom);
          endcase
          if (n < RANDOM_WORDS) send_word(r, 1'b0, none);
          n++;
        end
      end
    end
    in_valid <= 1'b0;

    while (avg_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d readings (%0d failed reads, %0d channel ring wraps), checked %0d results",
             words_sent, failed_reads, ring_wraps, results_checked);
    $display("under sender-idle, receiver-idle and back-to-back pacing; %0d mismatches",
             mismatches);
    if (mismatches == 0 && avg_expect_q.size() == 0)
      $display("PASS multichannel_angle_moving_average");
    else
      $display("FAIL multichannel_angle_moving_average");
    $finish;
  end

endmodule
